>>> rtl/vsh_pkg.sv
// shared types, constants and character classes for the version string parser
package vsh_pkg;

  typedef enum logic [3:0] {
    PH_START        = 4'd0,
    PH_MAJOR        = 4'd1,
    PH_MINOR_FIRST  = 4'd2,
    PH_MINOR        = 4'd3,
    PH_PATCH_FIRST  = 4'd4,
    PH_PATCH        = 4'd5,
    PH_SUFFIX_FIRST = 4'd6,
    PH_SUFFIX       = 4'd7,
    PH_FAILED       = 4'd8
  } phase_t;

  // one character beat held between the input register and the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] character;
  } char_beat_t;

  localparam logic [24:0] MAJOR_LIMIT = 25'd21474836;
  localparam logic [31:0] INT_MAX     = 32'd2147483647;
  localparam logic [1:0]  MINOR_SAT   = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_suffix_char(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
           ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           is_digit(c) || (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT);
  endfunction

endpackage

>>> rtl/vsh_in_stage.sv
// input register for character beats
module vsh_in_stage import vsh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] character,
  input  logic       advance,
  output char_beat_t beat
);

  logic       held;
  logic [7:0] held_char;
  logic       load;

  assign char_stall = held && !advance;
  assign load       = char_valid && !char_stall;
  assign beat       = '{valid: held, character: held_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!char_stall) begin
      held <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_char <= character;
    end
  end

  // a beat that the parser did not take stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    held && !advance |=> held && $stable(held_char))
    else $error("held character beat lost or changed");

endmodule

>>> rtl/vsh_parser.sv
// parse state update and result register
module vsh_parser import vsh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  char_beat_t  beat,
  output logic        advance,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        ok,
  output logic [30:0] hundredths
);

  phase_t      phase, phase_next;
  logic [24:0] major_acc, major_acc_next;
  logic [6:0]  minor_acc, minor_acc_next;
  logic [1:0]  minor_count, minor_count_next;

  logic        is_nul;
  logic        digit;
  logic [3:0]  d;
  logic [28:0] major_prod;
  logic [6:0]  minor_prod;
  logic [6:0]  frac;
  logic [31:0] total;
  logic        good;

  always_comb begin
    is_nul  = beat.character == CH_NUL;
    advance = beat.valid && (!is_nul || !result_valid || !result_stall);
    digit   = is_digit(beat.character);
    d       = beat.character[3:0];

    major_prod = {4'b0, major_acc} * 29'd10 + {25'b0, d};
    // at most one digit stored here, so the sum stays below 100
    minor_prod = minor_acc * 7'd10 + {3'b0, d};

    // a lone minor digit counts as tenths
    frac  = (minor_count == 2'd1) ? minor_acc * 7'd10 : minor_acc;
    total = {7'b0, major_acc} * 32'd100 + {25'b0, frac};
    good  = ((phase == PH_MAJOR) || (phase == PH_MINOR) ||
             (phase == PH_PATCH) || (phase == PH_SUFFIX)) && (total <= INT_MAX);
  end

  always_comb begin
    phase_next       = phase;
    major_acc_next   = major_acc;
    minor_acc_next   = minor_acc;
    minor_count_next = minor_count;
    if (advance) begin
      if (is_nul) begin
        phase_next       = PH_START;
        major_acc_next   = '0;
        minor_acc_next   = '0;
        minor_count_next = '0;
      end else begin
        unique case (phase) inside
          PH_START, PH_MAJOR: begin
            if (digit) begin
              if (major_prod > {4'b0, MAJOR_LIMIT}) begin
                phase_next = PH_FAILED;
              end else begin
                major_acc_next = major_prod[24:0];
                phase_next     = PH_MAJOR;
              end
            end else if (phase == PH_MAJOR && beat.character == CH_DOT) begin
              phase_next = PH_MINOR_FIRST;
            end else if (phase == PH_MAJOR && beat.character == CH_DASH) begin
              phase_next = PH_SUFFIX_FIRST;
            end else begin
              phase_next = PH_FAILED;
            end
          end
          PH_MINOR_FIRST, PH_MINOR: begin
            if (digit) begin
              if (minor_count < MINOR_SAT) begin
                minor_acc_next   = minor_prod;
                minor_count_next = minor_count + 2'd1;
              end
              phase_next = PH_MINOR;
            end else if (phase == PH_MINOR && beat.character == CH_DOT) begin
              phase_next = PH_PATCH_FIRST;
            end else if (phase == PH_MINOR && beat.character == CH_DASH) begin
              phase_next = PH_SUFFIX_FIRST;
            end else begin
              phase_next = PH_FAILED;
            end
          end
          PH_PATCH_FIRST, PH_PATCH: begin
            if (digit) begin
              phase_next = PH_PATCH;
            end else if (phase == PH_PATCH && beat.character == CH_DASH) begin
              phase_next = PH_SUFFIX_FIRST;
            end else begin
              phase_next = PH_FAILED;
            end
          end
          PH_SUFFIX_FIRST, PH_SUFFIX: begin
            phase_next = is_suffix_char(beat.character) ? PH_SUFFIX : PH_FAILED;
          end
          default: begin
            phase_next = PH_FAILED;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      major_acc   <= '0;
      minor_acc   <= '0;
      minor_count <= '0;
    end else begin
      phase       <= phase_next;
      major_acc   <= major_acc_next;
      minor_acc   <= minor_acc_next;
      minor_count <= minor_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && is_nul) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && is_nul) begin
      ok         <= good;
      hundredths <= good ? total[30:0] : '0;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !ok |-> hundredths == '0)
    else $error("failed result carries a value");

  a_major_range: assert property (@(posedge clk) disable iff (rst)
    major_acc <= MAJOR_LIMIT)
    else $error("major accumulator beyond limit");

  a_minor_empty: assert property (@(posedge clk) disable iff (rst)
    minor_count == 2'd0 |-> minor_acc == '0)
    else $error("minor value without minor digits");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    advance && is_nul |=> phase == PH_START && major_acc == '0 && result_valid)
    else $error("terminator did not restart the parser");

endmodule

>>> rtl/version_string_to_hundredths.sv
// top level of the streaming version string parser
//
//  channel   valid          stall          payload
//  input     char_valid     char_stall     character
//  result    result_valid   result_stall   ok, hundredths
//
// one character beat per cycle while char_stall is low; a string's result is registered after its nul beat
// has passed the input register; each beat updates phase and major value (times ten, compare)
// rst clears the parse state and the valid bits of both registers, the first string starts fresh
// a stalled result holds the next nul beat in the input register and stalls the input behind it
// characters before that nul are never held up by the result side
module version_string_to_hundredths import vsh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  output logic        char_stall,
  input  logic [7:0]  character,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        ok,
  output logic [30:0] hundredths
);

  char_beat_t beat;
  logic       advance;

  vsh_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .advance    (advance),
    .beat       (beat)
  );

  vsh_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .beat         (beat),
    .advance      (advance),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ok           (ok),
    .hundredths   (hundredths)
  );

endmodule

>>> verif/version_check.sv
// checker for the version string parser: follows both channels, predicts and compares results
module version_check import vsh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        char_valid,
  input  logic        char_stall,
  input  logic [7:0]  character,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        ok,
  input  logic [30:0] hundredths,
  output int          errors,
  output int          pending,
  output int          results_checked,
  output int          good_results
);

  typedef struct packed {
    logic        ok;
    logic [30:0] hundredths;
  } version_t;

  version_t    expected_versions[$];

  // parse state, tracks the block's state from the accepted beats
  phase_t      phase;
  logic [24:0] major_val;
  logic [6:0]  minor_val;
  logic [1:0]  minor_digits;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic suffix_ok(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
           is_dec(c) || (c == CH_DASH) || (c == CH_UNDER) || (c == CH_DOT);
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < 40)
      $display("error at result %0d: %s", results_checked, what);
    errors++;
  endtask

  task automatic clear_parse();
    phase        = PH_START;
    major_val    = '0;
    minor_val    = '0;
    minor_digits = '0;
  endtask

  task automatic parse_char(input logic [7:0] c);
    logic [31:0] digit;
    logic [31:0] grown;
    logic [31:0] frac;
    logic [63:0] total;
    logic        good;
    version_t    r;
    digit = 32'(c) - 32'(CH_ZERO);
    if (c == CH_NUL) begin
      good = (phase == PH_MAJOR) || (phase == PH_MINOR) || (phase == PH_PATCH) ||
             (phase == PH_SUFFIX);
      frac = 32'(minor_val);
      // a lone minor digit counts as tenths
      if (minor_digits == 2'd1)
        frac = frac * 10;
      total = 64'(major_val) * 100 + 64'(frac);
      if (total > 64'(INT_MAX))
        good = 1'b0;
      r.ok = good;
      r.hundredths = good ? total[30:0] : '0;
      expected_versions.push_back(r);
      clear_parse();
    end else begin
      case (phase)
        PH_START, PH_MAJOR: begin
          if (is_dec(c)) begin
            grown = 32'(major_val) * 10 + digit;
            if (grown > 32'(MAJOR_LIMIT)) begin
              phase = PH_FAILED;
            end else begin
              major_val = grown[24:0];
              phase = PH_MAJOR;
            end
          end else if (phase == PH_MAJOR && c == CH_DOT) begin
            phase = PH_MINOR_FIRST;
          end else if (phase == PH_MAJOR && c == CH_DASH) begin
            phase = PH_SUFFIX_FIRST;
          end else begin
            phase = PH_FAILED;
          end
        end
        PH_MINOR_FIRST, PH_MINOR: begin
          if (is_dec(c)) begin
            if (minor_digits < MINOR_SAT) begin
              minor_val = 7'(32'(minor_val) * 10 + digit);
              minor_digits++;
            end
            phase = PH_MINOR;
          end else if (phase == PH_MINOR && c == CH_DOT) begin
            phase = PH_PATCH_FIRST;
          end else if (phase == PH_MINOR && c == CH_DASH) begin
            phase = PH_SUFFIX_FIRST;
          end else begin
            phase = PH_FAILED;
          end
        end
        PH_PATCH_FIRST, PH_PATCH: begin
          if (is_dec(c))
            phase = PH_PATCH;
          else if (phase == PH_PATCH && c == CH_DASH)
            phase = PH_SUFFIX_FIRST;
          else
            phase = PH_FAILED;
        end
        PH_SUFFIX_FIRST, PH_SUFFIX: begin
          phase = suffix_ok(c) ? PH_SUFFIX : PH_FAILED;
        end
        default: begin
          phase = PH_FAILED;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    version_t want;
    if (rst) begin
      clear_parse();
      expected_versions.delete();
      errors = 0;
      results_checked = 0;
      good_results = 0;
    end else begin
      // result first: a result beat can never belong to a nul taken on the same edge
      if (result_valid && !result_stall) begin
        results_checked++;
        if (ok === 1'b1)
          good_results++;
        if (expected_versions.size() == 0) begin
          report_mismatch("result beat with no string pending");
        end else begin
          want = expected_versions.pop_front();
          if (ok !== want.ok)
            report_mismatch($sformatf("ok %b, expected %b", ok, want.ok));
          if (hundredths !== want.hundredths)
            report_mismatch($sformatf("hundredths %0d, expected %0d", hundredths,
                                      want.hundredths));
        end
      end
      if (char_valid && !char_stall)
        parse_char(character);
    end
    pending = expected_versions.size();
  end

endmodule

>>> verif/tb_top.sv
// testbench top for the version string parser: clock, reset, stimulus, back-pressure, verdict
module tb_top;
  import vsh_pkg::*;

  localparam int    IDLE_LIMIT   = 3000;
  localparam int    LONG_HOLD    = 400;
  localparam int    TARGET_CHARS = 1350;
  localparam string SUFFIX_SET   = "azAZmq09-_.";

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        char_valid   = 1'b0;
  logic        char_stall;
  logic [7:0]  character    = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        ok;
  logic [30:0] hundredths;

  int          errors;
  int          pending;
  int          results_checked;
  int          good_results;

  logic [7:0]  char_stream[$];
  int          strings_built = 0;
  int          results_taken = 0;
  int          idle_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  version_string_to_hundredths dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .character    (character),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ok           (ok),
    .hundredths   (hundredths)
  );

  version_check checker_i (
    .clk             (clk),
    .rst             (rst),
    .char_valid      (char_valid),
    .char_stall      (char_stall),
    .character       (character),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .ok              (ok),
    .hundredths      (hundredths),
    .errors          (errors),
    .pending         (pending),
    .results_checked (results_checked),
    .good_results    (good_results)
  );

  task automatic add_bytes(input logic [7:0] s[$]);
    foreach (s[i])
      char_stream.push_back(s[i]);
    char_stream.push_back(CH_NUL);
    strings_built++;
  endtask

  task automatic add_text(input string text);
    logic [7:0] s[$];
    foreach (text[i])
      s.push_back(text[i]);
    add_bytes(s);
  endtask

  task automatic add_random_string();
    logic [7:0] s[$];
    string      text;
    int         kind;
    int         n;
    int         k;
    int         major;
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      // plain noise
      n = $urandom_range(0, 6);
      repeat (n) s.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 7) == 0) begin
        // majors around the limit, sometimes one digit too many
        major = $urandom_range(0, 1) ? 21474836 : $urandom_range(21474830, 21474839);
        text = $sformatf("%0d", major);
        if ($urandom_range(0, 3) == 0)
          text = {text, $sformatf("%0d", $urandom_range(0, 9))};
      end else begin
        text = $sformatf("%0d", $urandom_range(0, 999));
        if ($urandom_range(0, 5) == 0)
          text = {"0", text};
      end
      if ($urandom_range(0, 3) != 0) begin
        text = {text, "."};
        n = $urandom_range(1, 4);
        repeat (n) text = {text, $sformatf("%0d", $urandom_range(0, 9))};
        if ($urandom_range(0, 2) == 0) begin
          text = {text, "."};
          n = $urandom_range(1, 3);
          repeat (n) text = {text, $sformatf("%0d", $urandom_range(0, 9))};
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        text = {text, "-"};
        n = $urandom_range(1, 6);
        repeat (n) begin
          k = $urandom_range(0, SUFFIX_SET.len() - 1);
          text = {text, SUFFIX_SET.substr(k, k)};
        end
      end
      foreach (text[i])
        s.push_back(text[i]);
      // broken variants: one byte replaced, or a dangling separator
      if (kind < 6) begin
        if ($urandom_range(0, 1))
          s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(1, 255));
        else
          s.push_back($urandom_range(0, 1) ? CH_DOT : CH_DASH);
      end
    end
    add_bytes(s);
  endtask

  // no-accept watchdog
  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("version_string_to_hundredths: mismatch");
        $finish;
      end
    end
  end

  // result side: random stalls, bursts without stalls, one long hold-off
  initial begin
    int   hold;
    logic burst;
    burst = 1'b0;
    forever begin
      if (results_taken % 16 == 0)
        burst = ($urandom_range(0, 3) == 0);
      if (results_taken == 12)
        hold = LONG_HOLD;
      else
        hold = burst ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!(result_valid && !result_stall));
      results_taken++;
    end
  end

  initial begin
    logic [7:0] odd_bytes[$];
    int         gap;
    logic       burst;

    // directed strings
    add_text("");
    add_text("0");
    add_text("21474836.47");
    add_text("21474836.48");
    add_text("214748369");
    add_text("7.");
    add_text("7-");
    add_text("3.5");
    add_text("4.567.89-rc_1.Z");
    add_text("1.2.3.4");
    add_text(".5");
    odd_bytes = '{8'hff, 8'h31, 8'h80};
    add_bytes(odd_bytes);
    while (char_stream.size() < TARGET_CHARS)
      add_random_string();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    burst = 1'b0;
    foreach (char_stream[i]) begin
      if (i == 0 || char_stream[i - 1] == CH_NUL)
        burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        char_valid <= 1'b0;
        character <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
      char_valid <= 1'b1;
      character <= char_stream[i];
      do @(posedge clk); while (char_stall);
    end
    char_valid <= 1'b0;

    // let the checker register the last nul beat before looking at the pending count
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("covered %0d strings in %0d character beats, %0d results checked, %0d valid",
             strings_built, char_stream.size(), results_checked, good_results);
    $display("included a %0d-cycle result hold-off to back up the input channel", LONG_HOLD);
    if (errors == 0)
      $display("version_string_to_hundredths: match");
    else
      $display("version_string_to_hundredths: mismatch");
    $finish;
  end

endmodule

>>> version_string_to_hundredths.f
rtl/vsh_pkg.sv
rtl/vsh_in_stage.sv
rtl/vsh_parser.sv
rtl/version_string_to_hundredths.sv
verif/version_check.sv
verif/tb_top.sv
